// ----- hw/rtl/assert_macros.svh -----
// assertion macros used by the top rtl file of the scan code decoder
// no dependencies; the bodies are left empty when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property that must hold at every edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst, prop)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)

`endif

`endif

// ----- hw/rtl/scs1_pkg.sv -----
// types, constants and key table for the scan code set 1 decoder
// no dependencies; used by scs1_decode and scancode_set1_to_ascii_decoder
package scs1_pkg;

   localparam logic [7:0] PREFIX_CODE  = 8'hE0;
   localparam int         RELEASE_BIT  = 7;

   typedef enum logic [3:0] {
      KIND_UNKNOWN   = 4'd0,
      KIND_PRINTABLE = 4'd1,
      KIND_ESCAPE    = 4'd2,
      KIND_ENTER     = 4'd3,
      KIND_BACKSPACE = 4'd4,
      KIND_LCTRL     = 4'd5,
      KIND_LSHIFT    = 4'd6,
      KIND_RSHIFT    = 4'd7,
      KIND_LALT      = 4'd8,
      KIND_CAPS      = 4'd9
   } key_kind_type;

   typedef struct packed {
      logic ctrl;
      logic shift;
      logic alt;
      logic caps;
   } flags_type;

   typedef struct packed {
      key_kind_type kind;
      logic [6:0]   ch;
   } entry_type;

   typedef struct packed {
      key_kind_type kind;
      logic [6:0]   ch;
      logic         is_press;
      flags_type    flags;
   } result_type;

   // us layout, letters held upper case
   function automatic entry_type key_lookup(input logic [6:0] code);
      entry_type e;
      e = '{KIND_UNKNOWN, 7'h00};
      case (code)
         7'h01: e = '{KIND_ESCAPE,    7'h00};
         7'h02: e = '{KIND_PRINTABLE, 7'h31};
         7'h03: e = '{KIND_PRINTABLE, 7'h32};
         7'h04: e = '{KIND_PRINTABLE, 7'h33};
         7'h05: e = '{KIND_PRINTABLE, 7'h34};
         7'h06: e = '{KIND_PRINTABLE, 7'h35};
         7'h07: e = '{KIND_PRINTABLE, 7'h36};
         7'h08: e = '{KIND_PRINTABLE, 7'h37};
         7'h09: e = '{KIND_PRINTABLE, 7'h38};
         7'h0A: e = '{KIND_PRINTABLE, 7'h39};
         7'h0B: e = '{KIND_PRINTABLE, 7'h30};
         7'h0C: e = '{KIND_PRINTABLE, 7'h2D};
         7'h0D: e = '{KIND_PRINTABLE, 7'h3D};
         7'h0E: e = '{KIND_BACKSPACE, 7'h08};
         7'h10: e = '{KIND_PRINTABLE, 7'h51};
         7'h11: e = '{KIND_PRINTABLE, 7'h57};
         7'h12: e = '{KIND_PRINTABLE, 7'h45};
         7'h13: e = '{KIND_PRINTABLE, 7'h52};
         7'h14: e = '{KIND_PRINTABLE, 7'h54};
         7'h15: e = '{KIND_PRINTABLE, 7'h59};
         7'h16: e = '{KIND_PRINTABLE, 7'h55};
         7'h17: e = '{KIND_PRINTABLE, 7'h49};
         7'h18: e = '{KIND_PRINTABLE, 7'h4F};
         7'h19: e = '{KIND_PRINTABLE, 7'h50};
         7'h1C: e = '{KIND_ENTER,     7'h0A};
         7'h1D: e = '{KIND_LCTRL,     7'h00};
         7'h1E: e = '{KIND_PRINTABLE, 7'h41};
         7'h1F: e = '{KIND_PRINTABLE, 7'h53};
         7'h20: e = '{KIND_PRINTABLE, 7'h44};
         7'h21: e = '{KIND_PRINTABLE, 7'h46};
         7'h22: e = '{KIND_PRINTABLE, 7'h47};
         7'h23: e = '{KIND_PRINTABLE, 7'h48};
         7'h24: e = '{KIND_PRINTABLE, 7'h4A};
         7'h25: e = '{KIND_PRINTABLE, 7'h4B};
         7'h26: e = '{KIND_PRINTABLE, 7'h4C};
         7'h27: e = '{KIND_PRINTABLE, 7'h3B};
         7'h28: e = '{KIND_PRINTABLE, 7'h27};
         7'h2A: e = '{KIND_LSHIFT,    7'h00};
         7'h2C: e = '{KIND_PRINTABLE, 7'h5A};
         7'h2D: e = '{KIND_PRINTABLE, 7'h58};
         7'h2E: e = '{KIND_PRINTABLE, 7'h43};
         7'h2F: e = '{KIND_PRINTABLE, 7'h56};
         7'h30: e = '{KIND_PRINTABLE, 7'h42};
         7'h31: e = '{KIND_PRINTABLE, 7'h4E};
         7'h32: e = '{KIND_PRINTABLE, 7'h4D};
         7'h33: e = '{KIND_PRINTABLE, 7'h2C};
         7'h34: e = '{KIND_PRINTABLE, 7'h2E};
         7'h35: e = '{KIND_PRINTABLE, 7'h2F};
         7'h36: e = '{KIND_RSHIFT,    7'h00};
         7'h38: e = '{KIND_LALT,      7'h00};
         7'h39: e = '{KIND_PRINTABLE, 7'h20};
         7'h3A: e = '{KIND_CAPS,      7'h00};
         default: e = '{KIND_UNKNOWN, 7'h00};
      endcase
      return e;
   endfunction

   // shifted form of a non-letter printable
   function automatic logic [6:0] shift_map(input logic [6:0] c);
      logic [6:0] r;
      r = c;
      case (c)
         7'h31: r = 7'h21;
         7'h32: r = 7'h40;
         7'h33: r = 7'h23;
         7'h34: r = 7'h24;
         7'h35: r = 7'h25;
         7'h36: r = 7'h5E;
         7'h37: r = 7'h26;
         7'h38: r = 7'h2A;
         7'h39: r = 7'h28;
         7'h30: r = 7'h29;
         7'h2C: r = 7'h3C;
         7'h2E: r = 7'h3E;
         7'h2F: r = 7'h3F;
         7'h3B: r = 7'h3A;
         7'h27: r = 7'h22;
         7'h5B: r = 7'h7B;
         7'h5D: r = 7'h7D;
         7'h2D: r = 7'h5F;
         7'h3D: r = 7'h2B;
         default: r = c;
      endcase
      return r;
   endfunction

endpackage

// ----- hw/rtl/scancode_set1_to_ascii_decoder.sv -----
// Scan code set 1 to ASCII key decoder, US layout.
// Depends on scs1_pkg, scs1_decode and assert_macros.svh.
//
// req_ channel: one raw keyboard byte per beat (req_scan_byte). rsp_ channel:
// one decoded key event per beat, with kind, character, press/release and the
// ctrl, shift, alt and caps lock state after that byte.
// An extended prefix byte (E0) is consumed and gives no rsp_ beat; every
// other byte gives exactly one, in order.
// A byte is held in the input register, then goes through table lookup and
// modifier update into the result register, which drives rsp_.
// Throughput: one byte per cycle, sustained, while rsp_stall stays low.
// When rsp_stall is high the result register holds its beat and the input
// register keeps one more byte; req_stall rises only when both are full and
// the waiting byte needs the result register. A waiting prefix byte never
// stalls. Modifier state moves only when a result is loaded.
// Reset (synchronous, active high) empties both registers and clears all
// modifier flags and caps lock.
module scancode_set1_to_ascii_decoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_scan_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [3:0] rsp_key_kind,
   output logic [6:0] rsp_char_code,
   output logic       rsp_is_press,
   output logic       rsp_ctrl_held,
   output logic       rsp_shift_held,
   output logic       rsp_alt_held,
   output logic       rsp_caps_on
);
   import scs1_pkg::*;
`include "assert_macros.svh"

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       out_valid_ff, out_valid_in;
   result_type result_ff;
   flags_type  flags_ff, flags_in;

   logic       is_prefix;
   result_type res;
   flags_type  flags_next;
   logic       out_free;
   logic       advance;
   logic       load_out;
   logic       req_fire;

   scs1_decode u_decode (
      .scan_byte  (in_byte_ff),
      .flags      (flags_ff),
      .is_prefix  (is_prefix),
      .res        (res),
      .flags_next (flags_next)
   );

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && (is_prefix || out_free);
   assign load_out  = advance && !is_prefix;
   assign req_stall = in_valid_ff && !advance;
   assign req_fire  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (load_out) begin
         out_valid_in = 1'b1;
      end else if (out_free) begin
         out_valid_in = 1'b0;
      end
   end

   assign flags_in = load_out ? flags_next : flags_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         flags_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         flags_ff     <= flags_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff <= req_scan_byte;
      end
      if (load_out) begin
         result_ff <= res;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_key_kind   = result_ff.kind;
   assign rsp_char_code  = result_ff.ch;
   assign rsp_is_press   = result_ff.is_press;
   assign rsp_ctrl_held  = result_ff.flags.ctrl;
   assign rsp_shift_held = result_ff.flags.shift;
   assign rsp_alt_held   = result_ff.flags.alt;
   assign rsp_caps_on    = result_ff.flags.caps;

   // a waiting prefix byte is always drained
   `ASSERT_IMPLIES(a_prefix_never_stalls, clock, reset, in_valid_ff && is_prefix, !req_stall)

   // flags only move when a result is loaded, so the shown beat matches state
   `ASSERT_IMPLIES(a_rsp_flags_match_state, clock, reset, out_valid_ff, result_ff.flags == flags_ff)

   // caps lock only flips on a caps press
   `ASSERT_IMPLIES(a_caps_only_on_press, clock, reset, !$past(reset) && (flags_ff.caps != $past(flags_ff.caps)), $past(load_out && res.kind == KIND_CAPS && res.is_press))

   // unmapped codes carry no character
   `ASSERT_IMPLIES(a_unknown_has_no_char, clock, reset, out_valid_ff && result_ff.kind == KIND_UNKNOWN, result_ff.ch == 7'h00)

endmodule

// ----- hw/rtl/scs1_decode.sv -----
// combinational decode of one registered scan code byte
// depends on scs1_pkg for the key table, shift map and types
module scs1_decode (
   input  logic [7:0]          scan_byte,
   input  scs1_pkg::flags_type flags,
   output logic                is_prefix,
   output scs1_pkg::result_type res,
   output scs1_pkg::flags_type flags_next
);
   import scs1_pkg::*;

   entry_type  entry;
   logic       pressed;
   logic       is_letter;
   logic [6:0] ch;

   assign is_prefix = (scan_byte == PREFIX_CODE);
   assign pressed   = !scan_byte[RELEASE_BIT];
   assign entry     = key_lookup(scan_byte[6:0]);
   assign is_letter = (entry.ch >= 7'h41) && (entry.ch <= 7'h5A);

   always_comb begin
      ch = entry.ch;
      if (entry.kind == KIND_PRINTABLE && pressed) begin
         if (is_letter) begin
            if (flags.shift == flags.caps) begin
               ch = entry.ch + 7'h20;
            end
         end else if (flags.shift) begin
            ch = shift_map(entry.ch);
         end
      end
   end

   always_comb begin
      flags_next = flags;
      case (entry.kind)
         KIND_LCTRL:  flags_next.ctrl  = pressed;
         KIND_LSHIFT: flags_next.shift = pressed;
         KIND_RSHIFT: flags_next.shift = pressed;
         KIND_LALT:   flags_next.alt   = pressed;
         KIND_CAPS: begin
            if (pressed) begin
               flags_next.caps = !flags.caps;
            end
         end
         default: flags_next = flags;
      endcase
   end

   assign res = '{kind: entry.kind, ch: ch, is_press: pressed, flags: flags_next};

endmodule
